@@ rtl/tbeq_pkg.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer package
// Shared constants, register indexes and the controller command type.
// ----------------------------------------------------------------------------
package tbeq_pkg;

  // Register widths and fixed-point fractions.
  localparam int COEF_W    = 17;
  localparam int GAIN_W    = 16;
  localparam int COEF_FRAC = 16;
  localparam int GAIN_FRAC = 12;

  // The multiplier's second operand holds a coefficient or a gain plus a sign bit.
  localparam int MUL_B_W = COEF_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  // Register values after reset.
  localparam logic [COEF_W-1:0] LOW_COEF_RST  = 17'd8212;
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = 17'd45707;
  localparam logic [GAIN_W-1:0] LOW_GAIN_RST  = 16'd6144;
  localparam logic [GAIN_W-1:0] MID_GAIN_RST  = 16'd3072;
  localparam logic [GAIN_W-1:0] HIGH_GAIN_RST = 16'd4096;

  // Band selected for a gain product.
  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // input transfer: latch sample, clear state on block start
    logic       pole_mul;  // multiply coefficient by (source - pole)
    logic       pole_upd;  // add the scaled product to the pole and saturate
    logic [2:0] pole_sel;  // bit 2 selects the high chain, bits 1:0 the stage
    logic       gain_mul;  // multiply a band by its gain
    band_t      gain_sel;
    logic       acc_first; // load the accumulator with the product
    logic       acc_add;   // add the product to the accumulator
    logic       finish;    // shift the delay line and load the output register
  } tbeq_cmd_t;

endpackage

@@ rtl/tbeq_in_if.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer input channel
// Valid/ready channel carrying one audio sample and the block start flag.
// ----------------------------------------------------------------------------
interface tbeq_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

@@ rtl/tbeq_out_if.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer result channel
// Valid/ready channel carrying one equalized sample and its clip flag.
// ----------------------------------------------------------------------------
interface tbeq_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

@@ rtl/tbeq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tbeq_cfg_if
  import tbeq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tbeq_datapath.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer datapath
// Configuration registers, pole and delay state, one shared multiplier,
// the band accumulator and the saturating output register.
// ----------------------------------------------------------------------------
module tbeq_datapath
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tbeq_cmd_t                     cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_start,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped
);

  localparam int GUARD  = POLE_BITS - SAMPLE_BITS;
  localparam int BW     = POLE_BITS + 2;      // band values and pole differences
  localparam int PW     = BW + MUL_B_W;       // product width
  localparam int SUMW   = POLE_BITS + 5;      // pole plus scaled product
  localparam int ACCW   = PW + 2;             // sum of three gain products
  localparam int OUT_SH = GAIN_FRAC + GUARD;

  // Configuration registers.
  logic [COEF_W-1:0] low_coef_r, high_coef_r;
  logic [GAIN_W-1:0] low_gain_r, mid_gain_r, high_gain_r;

  // Filter state: stages 0-3 form the low chain, stages 4-7 the high chain.
  logic signed [POLE_BITS-1:0]   pole_r [8];
  logic signed [SAMPLE_BITS-1:0] dly_r  [3];
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [POLE_BITS-1:0]   src_r;

  // Arithmetic registers.
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          clipped_r;

  logic signed [POLE_BITS-1:0] xp, dly_p, src, pole_cur, newp;
  logic signed [BW-1:0]        diff, band_lo, band_mid, band_hi, ma;
  logic signed [MUL_B_W-1:0]   mb;
  logic signed [PW-1:0]        prod;
  logic [COEF_W-1:0]           coef_sel;
  logic signed [SUMW-1:0]      shd, psum;
  logic [SUMW-POLE_BITS:0]     ptop;
  logic                        povf;
  logic signed [ACCW-1:0]      accs;
  logic [ACCW-SAMPLE_BITS:0]   otop;
  logic                        oovf;
  logic signed [SAMPLE_BITS-1:0] osat;

  // Bring the sample and the delayed sample to pole scale.
  if (GUARD >= 0) begin : g_scale_up
    assign xp    = POLE_BITS'(x_r) <<< GUARD;
    assign dly_p = POLE_BITS'(dly_r[2]) <<< GUARD;
  end else begin : g_scale_down
    assign xp    = POLE_BITS'(x_r >>> (-GUARD));
    assign dly_p = POLE_BITS'(dly_r[2] >>> (-GUARD));
  end

  // Stage input: the scaled sample for the first stage, else the previous pole.
  assign src      = (cmd.pole_sel[1:0] == 2'd0) ? xp : src_r;
  assign pole_cur = pole_r[cmd.pole_sel];
  assign diff     = BW'(src) - BW'(pole_cur);
  assign coef_sel = cmd.pole_sel[2] ? high_coef_r : low_coef_r;

  // Band values at pole scale.
  assign band_lo  = BW'(pole_r[3]);
  assign band_hi  = BW'(dly_p) - BW'(pole_r[7]);
  assign band_mid = BW'(dly_p) - band_lo - band_hi;

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = diff;
    mb = signed'(MUL_B_W'(coef_sel));
    if (cmd.gain_mul) begin
      unique case (cmd.gain_sel)
        BAND_LOW: begin
          ma = band_lo;
          mb = signed'(MUL_B_W'(low_gain_r));
        end
        BAND_MID: begin
          ma = band_mid;
          mb = signed'(MUL_B_W'(mid_gain_r));
        end
        BAND_HIGH: begin
          ma = band_hi;
          mb = signed'(MUL_B_W'(high_gain_r));
        end
        default: begin
          ma = band_lo;
          mb = signed'(MUL_B_W'(low_gain_r));
        end
      endcase
    end
  end

  assign prod = PW'(ma) * PW'(mb);

  // Pole update with saturation to the pole range.
  assign shd  = SUMW'(prod_r >>> COEF_FRAC);
  assign psum = SUMW'(pole_cur) + shd;
  assign ptop = psum[SUMW-1:POLE_BITS-1];
  assign povf = !((&ptop) || (~|ptop));
  assign newp = !povf ? psum[POLE_BITS-1:0] :
                psum[SUMW-1] ? {1'b1, {(POLE_BITS-1){1'b0}}} :
                               {1'b0, {(POLE_BITS-1){1'b1}}};

  // Output scaling with saturation to the sample range.
  assign accs = acc_r >>> OUT_SH;
  assign otop = accs[ACCW-1:SAMPLE_BITS-1];
  assign oovf = !((&otop) || (~|otop));
  assign osat = !oovf ? accs[SAMPLE_BITS-1:0] :
                accs[ACCW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                               {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_coef_r  <= LOW_COEF_RST;
      high_coef_r <= HIGH_COEF_RST;
      low_gain_r  <= LOW_GAIN_RST;
      mid_gain_r  <= MID_GAIN_RST;
      high_gain_r <= HIGH_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_COEF:  low_coef_r  <= cfg_data;
        REG_HIGH_COEF: high_coef_r <= cfg_data;
        REG_LOW_GAIN:  low_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_MID_GAIN:  mid_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_HIGH_GAIN: high_gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter and delay state, cleared at reset and at a block start.
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && block_start)) begin
      for (int i = 0; i < 8; i++) pole_r[i] <= '0;
      for (int i = 0; i < 3; i++) dly_r[i] <= '0;
    end else begin
      if (cmd.pole_upd) begin
        pole_r[cmd.pole_sel] <= newp;
      end
      if (cmd.finish) begin
        dly_r[2] <= dly_r[1];
        dly_r[1] <= dly_r[0];
        dly_r[0] <= x_r;
      end
    end
  end

  // Sample latch, multiplier, accumulator and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= sample_in;
    end
    if (cmd.pole_upd) begin
      src_r <= newp;
    end
    if (cmd.pole_mul || cmd.gain_mul) begin
      prod_r <= prod;
    end
    if (cmd.acc_add) begin
      acc_r <= cmd.acc_first ? ACCW'(prod_r) : acc_r + ACCW'(prod_r);
    end
    if (cmd.finish) begin
      sample_out_r <= osat;
      clipped_r    <= oovf;
    end
  end

  assign sample_out = sample_out_r;
  assign clipped    = clipped_r;

endmodule

@@ rtl/tbeq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer controller
// Sequences the eight pole stages and three gain products over the shared
// multiplier and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module tbeq_ctrl
  import tbeq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tbeq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAIN,
    S_GAIN,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // The output register is free once its result has been taken.
  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Datapath commands decoded from state and step count.
  always_comb begin
    cmd           = '0;
    cmd.load      = in_valid && in_ready;
    cmd.pole_sel  = cnt_r[3:1];
    cmd.gain_sel  = band_t'(cnt_r[1:0]);
    cmd.pole_mul  = (state_r == S_CHAIN) && !cnt_r[0];
    cmd.pole_upd  = (state_r == S_CHAIN) && cnt_r[0];
    cmd.gain_mul  = (state_r == S_GAIN) && (cnt_r[1:0] != 2'd3);
    cmd.acc_add   = (state_r == S_GAIN) && (cnt_r[1:0] != 2'd0);
    cmd.acc_first = (cnt_r[1:0] == 2'd1);
    cmd.finish    = fin_go;
  end

  // Next state, step count and result valid.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_CHAIN;
        end
      end
      S_CHAIN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The shared multiplier never serves a pole and a gain in the same cycle.
  a_one_mul: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pole_mul && cmd.gain_mul))
    else $error("pole and gain products requested together");

  // Every pole product is followed by the update of the same stage.
  a_mul_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pole_mul |=> cmd.pole_upd && (cmd.pole_sel == $past(cmd.pole_sel)))
    else $error("pole product not followed by its update");

  // A finished item always shows up as a pending result.
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished item did not raise result valid");

  // No second item is taken while one is in flight.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("input accepted while busy");

endmodule

@@ rtl/three_band_equalizer.sv @@
// ----------------------------------------------------------------------------
// Three-band equalizer
// Low, mid and high bands from two chains of four one-pole stages, gain per
// band, summed and saturated with a clip flag.
// ----------------------------------------------------------------------------
// From its input transfer until the block is ready for the next sample, each
// sample passes through a multiply step and an update step for each of the
// eight pole stages, the gain steps for the three gain products and their
// accumulation, a step to load the output register and the idle state that
// takes the next sample. The single shared multiplier makes these steps run
// in sequence. A result waits in the output register while the next sample is
// already being processed; the block stalls only in its finish state if that
// register is still occupied. A sample with block_start set clears all pole
// and delay state before it is filtered; the configuration registers keep
// their values. Configuration writes are always taken and should be made
// while no sample is in flight.
module three_band_equalizer
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24
) (
  input logic   clk,
  input logic   rst_n,
  tbeq_in_if.sink    in_ch,
  tbeq_out_if.source out_ch,
  tbeq_cfg_if.sink   cfg_ch
);

  tbeq_cmd_t cmd;

  // Configuration writes are always accepted.
  assign cfg_ch.ready = 1'b1;

  tbeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tbeq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .POLE_BITS   (POLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sample_in   (in_ch.sample_in),
    .block_start (in_ch.block_start),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .sample_out  (out_ch.sample_out),
    .clipped     (out_ch.clipped)
  );

endmodule

@@ tb/sv/tbeq_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-band equalizer result checker
// Watches the configuration, sample and result channels, keeps its own copy
// of the filter state and registers, predicts every equalized sample and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module tbeq_checker
  import tbeq_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int POLE_BITS   = 24
) (
  input  logic clk,
  input  logic rst_n,
  tbeq_in_if   in_ch,
  tbeq_out_if  out_ch,
  tbeq_cfg_if  cfg_ch,
  output int   error_count,
  output int   pending_count
);

  // Poles carry the sample at this many extra fraction bits.
  localparam int GUARD = POLE_BITS - SAMPLE_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } eq_result_t;

  // Shadow registers and filter state.
  logic [COEF_W-1:0]             low_coef, high_coef;
  logic [GAIN_W-1:0]             low_gain, mid_gain, high_gain;
  logic signed [POLE_BITS-1:0]   low_poles [4];
  logic signed [POLE_BITS-1:0]   high_poles [4];
  logic signed [SAMPLE_BITS-1:0] sample_history [3];

  eq_result_t expected_q [$];
  eq_result_t want;
  eq_result_t predicted;
  int         result_count;

  // Saturate a wide value to a signed range of the given width.
  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Bring a sample to pole scale; a negative guard rounds toward minus infinity.
  function automatic longint to_pole_scale(input longint x);
    if (GUARD >= 0) return x <<< GUARD;
    return x >>> (-GUARD);
  endfunction

  // One one-pole stage: p += floor(coef * (src - p) / 2^16), saturated.
  function automatic longint pole_step(input longint src, input longint pole,
                                       input logic [COEF_W-1:0] coef);
    longint prod;
    prod = (src - pole) * longint'(coef);
    return clamp(pole + (prod >>> COEF_FRAC), POLE_BITS);
  endfunction

  // Advance the equalizer by one sample and return the equalized result.
  task automatic equalize(input logic signed [SAMPLE_BITS-1:0] sample,
                          input logic block_start, output eq_result_t r);
    longint src, delayed, lo_band, hi_band, mid_band, acc;
    if (block_start) begin
      foreach (low_poles[i]) begin
        low_poles[i]  = '0;
        high_poles[i] = '0;
      end
      foreach (sample_history[i]) sample_history[i] = '0;
    end

    src = to_pole_scale(longint'(sample));
    for (int i = 0; i < 4; i++) begin
      low_poles[i] = POLE_BITS'(pole_step(src, longint'(low_poles[i]), low_coef));
      src = longint'(low_poles[i]);
    end
    lo_band = src;

    src = to_pole_scale(longint'(sample));
    for (int i = 0; i < 4; i++) begin
      high_poles[i] = POLE_BITS'(pole_step(src, longint'(high_poles[i]), high_coef));
      src = longint'(high_poles[i]);
    end
    delayed  = to_pole_scale(longint'(sample_history[2]));
    hi_band  = delayed - src;
    mid_band = delayed - lo_band - hi_band;

    sample_history[2] = sample_history[1];
    sample_history[1] = sample_history[0];
    sample_history[0] = sample;

    acc = lo_band * longint'(low_gain) + mid_band * longint'(mid_gain)
        + hi_band * longint'(high_gain);
    acc = acc >>> (GAIN_FRAC + GUARD);
    r.clipped = (acc != clamp(acc, SAMPLE_BITS));
    r.sample  = SAMPLE_BITS'(clamp(acc, SAMPLE_BITS));
  endtask

  // Count a mismatch and print one line for it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t tbeq_checker: %s", $time, what);
  endtask

  // Register writes, result comparison, then prediction for a new sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      low_coef  = LOW_COEF_RST;
      high_coef = HIGH_COEF_RST;
      low_gain  = LOW_GAIN_RST;
      mid_gain  = MID_GAIN_RST;
      high_gain = HIGH_GAIN_RST;
      foreach (low_poles[i]) begin
        low_poles[i]  = '0;
        high_poles[i] = '0;
      end
      foreach (sample_history[i]) sample_history[i] = '0;
      expected_q.delete();
      result_count = 0;
      error_count  = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_LOW_COEF:  low_coef  = cfg_ch.data;
          REG_HIGH_COEF: high_coef = cfg_ch.data;
          REG_LOW_GAIN:  low_gain  = cfg_ch.data[GAIN_W-1:0];
          REG_MID_GAIN:  mid_gain  = cfg_ch.data[GAIN_W-1:0];
          REG_HIGH_GAIN: high_gain = cfg_ch.data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with no sample pending, sample_out %0d",
                                    out_ch.sample_out));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.sample_out !== want.sample)
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      result_count, out_ch.sample_out, want.sample));
          if (out_ch.clipped !== want.clipped)
            report_mismatch($sformatf("result %0d: clipped %b, expected %b",
                                      result_count, out_ch.clipped, want.clipped));
        end
        result_count++;
      end

      if (in_ch.valid && in_ch.ready) begin
        equalize(in_ch.sample_in, in_ch.block_start, predicted);
        expected_q.push_back(predicted);
      end
    end
    pending_count = expected_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Three-band equalizer testbench
// Drives directed and random audio blocks through the equalizer under a
// series of coefficient and gain settings, with bursty input traffic and a
// stalling result receiver. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import tbeq_pkg::*;

  localparam int SAMPLE_BITS    = 16;
  localparam int POLE_BITS      = 24;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_SAMPLES  = 138;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int CYCLE_LIMIT    = 600000;

  localparam logic [CFG_DATA_W-1:0] DATA_MAX = '1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;

  typedef enum {RX_FREE, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;
  typedef enum {SIG_NOISE, SIG_QUIET, SIG_SQUARE, SIG_RAMP} sig_style_t;
  typedef enum {SET_FULL, SET_TYPICAL, SET_EDGES, SET_DEFAULT, SET_HOT} set_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   error_count;
  int   pending_count;
  int   cycle_count;
  int   burst_left;
  bit   hold_off_req;

  tbeq_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  tbeq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
  tbeq_cfg_if cfg_ch ();

  three_band_equalizer #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POLE_BITS  (POLE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  tbeq_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POLE_BITS  (POLE_BITS)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  always #2 clk = ~clk;

  // Give up after a generous number of cycles.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  // Result receiver: changing stall modes, plus a long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    out_ch.ready = 1'b0;
    mode      = RX_FREE;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_FREE:    out_ch.ready <= 1'b1;
        RX_LIGHT:   out_ch.ready <= ($urandom_range(0, 9) >= 3);
        RX_PATTERN: out_ch.ready <= (tick % 8 >= 5);
        default:    out_ch.ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
  end

  // Offer one sample; bursts of random length are separated by random gaps.
  // Called and returning at a falling edge, with valid left high.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] sample,
                             input logic block_start);
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.sample_in   <= sample;
    in_ch.block_start <= block_start;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every predicted result to arrive.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // One register write transfer; valid is left high for back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Write all five registers, sometimes also an unused index.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] lc, hc, lg, mg, hg);
    write_reg(REG_LOW_COEF, lc);
    write_reg(REG_HIGH_COEF, hc);
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(REG_HIGH_GAIN + 1 + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom));
    write_reg(REG_LOW_GAIN, lg);
    write_reg(REG_MID_GAIN, mg);
    write_reg(REG_HIGH_GAIN, hg);
    cfg_ch.valid <= 1'b0;
  endtask

  // Zero, all ones or anything.
  function automatic logic [CFG_DATA_W-1:0] edge_value();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return '0;
    if (pick == 1) return DATA_MAX;
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sig_style_t style,
                                                                input int pos);
    case (style)
      SIG_NOISE:  return SAMPLE_BITS'($urandom);
      SIG_QUIET:  return SAMPLE_BITS'($urandom_range(0, 1024) - 512);
      SIG_SQUARE: return pos[2] ? S_MAX : S_MIN;
      default:    return SAMPLE_BITS'(pos * 2113 - 20000);
    endcase
  endfunction

  // Directed samples at the reset settings: extremes, full-scale steps and
  // block starts both at the head and in the middle of a stream.
  logic signed [SAMPLE_BITS-1:0] dir_samples [22] = '{
    0, S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, 1, -1,
    S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 0, 0, 16384, -16384
  };
  logic dir_starts [22] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0
  };

  // Main stimulus.
  initial begin : stimulus
    set_kind_t  kind;
    sig_style_t style;
    int         sent;
    int         block_len;
    logic       start_flag;
    logic [CFG_DATA_W-1:0] lc, hc, lg, mg, hg;

    in_ch.valid       = 1'b0;
    in_ch.sample_in   = '0;
    in_ch.block_start = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_LOW_COEF;
    cfg_ch.data       = '0;
    hold_off_req      = 1'b0;
    burst_left        = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_samples[i]) send_sample(dir_samples[i], dir_starts[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();

      // The first two phases pin every register at its top and bottom.
      if (phase == 0) begin
        lc = DATA_MAX; hc = DATA_MAX; lg = DATA_MAX; mg = DATA_MAX; hg = DATA_MAX;
      end else if (phase == 1) begin
        lc = '0; hc = '0; lg = '0; mg = '0; hg = '0;
      end else begin
        kind = set_kind_t'($urandom_range(0, 4));
        case (kind)
          SET_FULL: begin
            lc = CFG_DATA_W'($urandom); hc = CFG_DATA_W'($urandom);
            lg = CFG_DATA_W'($urandom); mg = CFG_DATA_W'($urandom);
            hg = CFG_DATA_W'($urandom);
          end
          SET_TYPICAL: begin
            lc = CFG_DATA_W'($urandom_range(1000, 20000));
            hc = CFG_DATA_W'($urandom_range(20000, 90000));
            lg = CFG_DATA_W'($urandom_range(0, 16384));
            mg = CFG_DATA_W'($urandom_range(0, 16384));
            hg = CFG_DATA_W'($urandom_range(0, 16384));
          end
          SET_EDGES: begin
            lc = edge_value(); hc = edge_value();
            lg = edge_value(); mg = edge_value(); hg = edge_value();
          end
          SET_DEFAULT: begin
            lc = LOW_COEF_RST; hc = HIGH_COEF_RST;
            lg = CFG_DATA_W'(LOW_GAIN_RST); mg = CFG_DATA_W'(MID_GAIN_RST);
            hg = CFG_DATA_W'(HIGH_GAIN_RST);
          end
          default: begin
            // Coefficients near two make the stages ring and saturate.
            lc = CFG_DATA_W'($urandom_range(120000, 131071));
            hc = CFG_DATA_W'($urandom_range(120000, 131071));
            lg = CFG_DATA_W'($urandom); mg = CFG_DATA_W'($urandom);
            hg = CFG_DATA_W'($urandom);
          end
        endcase
      end
      load_settings(lc, hc, lg, mg, hg);

      // Mostly well-formed blocks that open with a block start, with the
      // occasional stray block start in the middle.
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        block_len = $urandom_range(4, 40);
        style     = sig_style_t'($urandom_range(0, 3));
        for (int k = 0; k < block_len && sent < PHASE_SAMPLES; k++) begin
          start_flag = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
          if ((phase == 4 || phase == 9) && sent == 10) hold_off_req = 1'b1;
          if (phase % 3 == 2 && sent == PHASE_SAMPLES / 2) wait_drained();
          send_sample(pick_sample(style, k), start_flag);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
